// ===== rtl/drpv_pkg.sv =====
// ============================================================================
// drpv_pkg
// Shared types, constants and tables for the dead-reckoning place vector.
// ============================================================================
package drpv_pkg;

    localparam int PANO_LEN  = 24;
    localparam int PIDX_W    = 5;
    localparam int REPS      = (PANO_LEN / 4 < 1) ? 1 : PANO_LEN / 4;
    localparam int TOTAL     = PANO_LEN + 4 * REPS;
    localparam int CNT_W     = 6;
    localparam int CORDIC_IT = 24;
    localparam int CW        = 30;

    localparam logic signed [CW-1:0] PI_Q        = 30'sd52707179;
    localparam logic signed [CW-1:0] HALF_PI_Q   = 30'sd26353589;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 30'sd10188014;
    localparam logic signed [47:0]   ACC_MAX     = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0]   ACC_MIN     = 48'sh8000_0000_0000;
    localparam logic [23:0]          RECIP_RESET = 24'd69905;

    localparam logic [1:0] OP_PANO = 2'd0;
    localparam logic [1:0] OP_HEAD = 2'd1;
    localparam logic [1:0] OP_VEL  = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    localparam logic [2:0] KIND_PANO = 3'd0;
    localparam logic [2:0] KIND_X    = 3'd1;
    localparam logic [2:0] KIND_Y    = 3'd2;
    localparam logic [2:0] KIND_COS  = 3'd3;
    localparam logic [2:0] KIND_SIN  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_M0, ST_M1, ST_M2, ST_M3,
        ST_P0, ST_P1,
        ST_EMIT
    } state_t;

    // arctangent step table in Q.24
    function automatic logic signed [CW-1:0] atan_step(input logic [4:0] i);
        logic signed [CW-1:0] r;
        begin
            case (i)
                5'd0: r = 30'sd13176795;
                5'd1: r = 30'sd7778716;
                5'd2: r = 30'sd4110060;
                5'd3: r = 30'sd2086331;
                5'd4: r = 30'sd1047214;
                5'd5: r = 30'sd524117;
                5'd6: r = 30'sd262123;
                5'd7: r = 30'sd131069;
                default: r = CW'(signed'(31'sd1 <<< (5'd24 - i)));
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [17:0] clamp1(input logic signed [47:0] v);
        logic signed [17:0] r;
        begin
            if (v > 48'sd65536)
                r = 18'sd65536;
            else if (v < -48'sd65536)
                r = -18'sd65536;
            else
                r = v[17:0];
            return r;
        end
    endfunction

endpackage

// ===== rtl/drpv_cordic.sv =====
// ============================================================================
// drpv_cordic
// Iterative rotation unit: one micro-rotation per cycle, 24 micro-rotations,
// done raised the cycle after the last one.
// ============================================================================
module drpv_cordic
    import drpv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [15:0]       heading,
    output logic                     done,
    output logic signed [17:0]       cos_q,
    output logic signed [17:0]       sin_q
);

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic                 flip_reg;
    logic [4:0]           it_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [CW-1:0] z0;
    logic signed [CW-1:0] dx, dy, a;
    logic signed [CW-1:0] xr, yr;

    // scale heading to the Q.24 angle; the fold into [-pi/2, pi/2] is done at start
    always_comb
    begin
        z0 = CW'(heading) <<< 11;
        dx = y_reg >>> it_reg;
        dy = x_reg >>> it_reg;
        a  = atan_step(it_reg);
        xr = (x_reg + CW'(128)) >>> 8;
        yr = (y_reg + CW'(128)) >>> 8;
    end

    // iteration counter; done follows the final micro-rotation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (it_reg == 5'(CORDIC_IT - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + 5'd1;
                if (it_reg == 5'(CORDIC_IT - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            if (z0 > HALF_PI_Q)
            begin
                z_reg <= z0 - PI_Q;  flip_reg <= 1'b1;
            end
            else if (z0 < -HALF_PI_Q)
            begin
                z_reg <= z0 + PI_Q;  flip_reg <= 1'b1;
            end
            else
            begin
                z_reg <= z0;  flip_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - dx; y_reg <= y_reg + dy; z_reg <= z_reg - a;
            end
            else
            begin
                x_reg <= x_reg + dx; y_reg <= y_reg - dy; z_reg <= z_reg + a;
            end
        end
    end

    assign done  = done_reg;
    assign cos_q = clamp1(flip_reg ? -48'(xr) : 48'(xr));
    assign sin_q = clamp1(flip_reg ? -48'(yr) : 48'(yr));

endmodule

// ===== rtl/drpv_core.sv =====
// ============================================================================
// drpv_core
// Sequencer with one shared multiplier for odometry and position scaling.
// ============================================================================
module drpv_core
    import drpv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [4:0]         pano_index,
    input  logic [16:0]        pano_value,
    input  logic signed [15:0] heading_in,
    input  logic signed [15:0] vel_lateral,
    input  logic signed [15:0] vel_forward,
    input  logic [23:0]        recip,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] value,
    output logic [2:0]         kind,
    output logic               last
);

    state_t state_reg, state_next;

    logic [16:0]        pano_mem [PANO_LEN];
    logic signed [15:0] head_reg, lat_reg, fwd_reg;
    logic signed [47:0] xacc_reg, yacc_reg;
    logic signed [47:0] dsum_reg;
    logic signed [17:0] c_reg, s_reg, px_reg, py_reg;
    logic signed [17:0] cos_w, sin_w;
    logic               cdone;
    logic [CNT_W-1:0]   cnt_reg;
    logic [16:0]        pano_rd;

    // shared multiplier operands
    logic signed [34:0] ma;
    logic signed [24:0] mb;
    logic signed [59:0] prod;
    logic signed [48:0] sum49;
    logic signed [47:0] sat_sum;
    logic signed [47:0] acc_sel;
    logic signed [47:0] pos_w;
    logic               take;

    assign take     = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    drpv_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (take && op == OP_TICK),
        .heading (head_reg),
        .done    (cdone),
        .cos_q   (cos_w),
        .sin_q   (sin_w)
    );

    // operand selection per step
    always_comb
    begin
        acc_sel = (state_reg == ST_P1) ? yacc_reg : xacc_reg;
        case (state_reg)
            ST_M0:   begin ma = 35'(fwd_reg); mb = 25'(s_reg); end
            ST_M1:   begin ma = 35'(lat_reg); mb = 25'(c_reg); end
            ST_M2:   begin ma = 35'(fwd_reg); mb = 25'(c_reg); end
            ST_M3:   begin ma = 35'(lat_reg); mb = 25'(s_reg); end
            default: begin ma = 35'(acc_sel >>> 14); mb = 25'({1'b0, recip}); end
        endcase
        prod    = ma * mb;
        // x: -fwd*sin + lat*cos, y: -fwd*cos - lat*sin
        sum49   = 49'(xacc_reg) + 49'(dsum_reg + 48'(prod));
        if (state_reg == ST_M3)
            sum49 = 49'(yacc_reg) + 49'(dsum_reg - 48'(prod));
        if (sum49 > 49'(ACC_MAX))
            sat_sum = ACC_MAX;
        else if (sum49 < 49'(ACC_MIN))
            sat_sum = ACC_MIN;
        else
            sat_sum = sum49[47:0];
        pos_w = 48'((prod + 60'sd8388608) >>> 24);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (take && op == OP_TICK) state_next = ST_CORDIC;
            ST_CORDIC: if (cdone) state_next = ST_M0;
            ST_M0:     state_next = ST_M1;
            ST_M1:     state_next = ST_M2;
            ST_M2:     state_next = ST_M3;
            ST_M3:     state_next = ST_P0;
            ST_P0:     state_next = ST_P1;
            ST_P1:     state_next = ST_EMIT;
            ST_EMIT:
                if (!out_stall && cnt_reg == CNT_W'(TOTAL - 1))
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            head_reg  <= '0;
            lat_reg   <= '0;
            fwd_reg   <= '0;
            xacc_reg  <= '0;
            yacc_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (take && op == OP_HEAD)
                head_reg <= heading_in;
            if (take && op == OP_VEL)
            begin
                lat_reg <= vel_lateral;
                fwd_reg <= vel_forward;
            end
            case (state_reg)
                ST_M1:
                begin
                    xacc_reg <= sat_sum;
                end
                ST_M3:
                begin
                    yacc_reg <= sat_sum;
                    lat_reg  <= '0;
                    fwd_reg  <= '0;
                end
                ST_P1:   cnt_reg <= '0;
                ST_EMIT: if (!out_stall) cnt_reg <= cnt_reg + CNT_W'(1);
                default: ;
            endcase
        end
    end

    // datapath scratch registers
    always_ff @(posedge clk)
    begin
        if (cdone)
        begin
            c_reg <= cos_w;
            s_reg <= sin_w;
        end
        case (state_reg)
            ST_M0: dsum_reg <= -48'(prod);
            ST_M1: dsum_reg <= 48'(prod);
            ST_M2: dsum_reg <= -48'(prod);
            ST_P0: px_reg <= clamp1(pos_w);
            ST_P1: py_reg <= clamp1(pos_w);
            default: ;
        endcase
    end

    // panorama store, saturated on write, reads zero until written (valid bits)
    logic [PANO_LEN-1:0] pvalid_reg;
    logic [PIDX_W-1:0]   rd_idx;
    assign rd_idx = (state_reg == ST_EMIT && !out_stall) ?
                    PIDX_W'(cnt_reg + CNT_W'(1)) : PIDX_W'(0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pvalid_reg <= '0;
        else if (take && op == OP_PANO && pano_index < PIDX_W'(PANO_LEN))
            pvalid_reg[pano_index] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (take && op == OP_PANO && pano_index < PIDX_W'(PANO_LEN))
            pano_mem[pano_index] <= (pano_value > 17'd65536) ? 17'd65536 : pano_value;
    end

    logic [16:0] mem_q_reg;
    logic        mem_v_reg;
    logic [PIDX_W-1:0] hold_idx;
    assign hold_idx = (state_reg == ST_EMIT) ? PIDX_W'(cnt_reg) : rd_idx;
    always_ff @(posedge clk)
    begin
        if (state_reg != ST_EMIT || !out_stall)
        begin
            mem_q_reg <= pano_mem[(state_reg == ST_EMIT) ? rd_idx : PIDX_W'(0)];
            mem_v_reg <= (state_reg == ST_EMIT) ?
                         (rd_idx < PIDX_W'(PANO_LEN) && pvalid_reg[rd_idx]) : pvalid_reg[0];
        end
        else
        begin
            mem_q_reg <= pano_mem[hold_idx];
            mem_v_reg <= pvalid_reg[hold_idx];
        end
    end
    assign pano_rd = mem_v_reg ? mem_q_reg : 17'd0;

    // output element selection
    logic [CNT_W-1:0] rel;
    always_comb
    begin
        rel = cnt_reg - CNT_W'(PANO_LEN);
        if (cnt_reg < CNT_W'(PANO_LEN))
        begin
            value = 18'(pano_rd);
            kind  = KIND_PANO;
        end
        else
        begin
            case (rel[1:0])
                2'd0:    begin value = px_reg; kind = KIND_X;   end
                2'd1:    begin value = py_reg; kind = KIND_Y;   end
                2'd2:    begin value = c_reg;  kind = KIND_COS; end
                default: begin value = s_reg;  kind = KIND_SIN; end
            endcase
        end
    end

    assign out_valid = (state_reg == ST_EMIT);
    assign last      = (cnt_reg == CNT_W'(TOTAL - 1));

endmodule

// ===== rtl/dead_reckoning_place_vector_top.sv =====
// ============================================================================
// dead_reckoning_place_vector_top
// Dead-reckoning integrator with place vector output.
// ============================================================================
// Input channel (in_valid / in_stall) takes one event item: panorama element,
// heading, velocity or tick. Non-tick items do not stall the input and give
// no output. A tick holds in_stall high while it runs: the rotation unit (24
// micro-rotations, one a cycle, then a capture of cosine and sine), velocity
// products (ST_M0 to ST_M3) and position scaling (ST_P0, ST_P1) on one shared
// multiplier, then 48 output items at one per cycle when the receiver does
// not stall. The input stays held until the final output item is taken.
// Output items (out_valid / out_stall) hold while out_stall is high; last
// marks the final element. The recip_reg register is written through
// cfg_valid / cfg_ready, ready always; the user must write it only while
// idle, which the block itself does not enforce.
// Reset clears heading, velocity latches, accumulators and the panorama
// store (valid bits), and loads recip_reg with about 1/240.
// ============================================================================
module dead_reckoning_place_vector_top
    import drpv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [4:0]         pano_index,
    input  logic [16:0]        pano_value,
    input  logic signed [15:0] heading_in,
    input  logic signed [15:0] vel_lateral,
    input  logic signed [15:0] vel_forward,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] value,
    output logic [2:0]         kind,
    output logic               last
);

    logic [23:0] recip_reg;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            recip_reg <= RECIP_RESET;
        else if (cfg_valid && cfg_ready)
            recip_reg <= cfg_data;
    end

    drpv_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .pano_index  (pano_index),
        .pano_value  (pano_value),
        .heading_in  (heading_in),
        .vel_lateral (vel_lateral),
        .vel_forward (vel_forward),
        .recip       (recip_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .kind        (kind),
        .last        (last)
    );

endmodule

// ===== rtl/drpv_checker.sv =====
// ============================================================================
// drpv_checker
// Port-level checks on the place vector block.
// ============================================================================
module drpv_checker
    import drpv_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  kind,
    input logic        last
);

    // a stalled output item keeps its kind and last flag
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last))
        else $error("output item changed under stall");

    // output only while input is blocked
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("output while input open");

    // last is always a sine element
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> kind == KIND_SIN)
        else $error("last on wrong kind");

    // after the final item the block reopens
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && !out_stall |=> !out_valid && !in_stall)
        else $error("block did not return to idle");

endmodule

bind dead_reckoning_place_vector_top drpv_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .last      (last)
);
